>>> hw/rtl/ipv6w_pkg.sv
// ----------------------------------------------------------------------------
// ipv6w_pkg
// Shared types and constants for the IPv6 extension header walker: beat and
// result records, parse phases, next-header values and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6w_pkg;

    // base header size, also the offset of the first extension header
    localparam logic [16:0] BASE_LEN = 17'd40;

    // smallest ICMPv6 message that counts as reached
    localparam logic [16:0] ICMP6_MIN = 17'd8;

    localparam logic [3:0] EXT_COUNT_MAX = 4'd15;

    // next-header values
    localparam logic [7:0] NH_HOPOPT  = 8'd0;
    localparam logic [7:0] NH_TCP     = 8'd6;
    localparam logic [7:0] NH_UDP     = 8'd17;
    localparam logic [7:0] NH_ROUTING = 8'd43;
    localparam logic [7:0] NH_FRAG    = 8'd44;
    localparam logic [7:0] NH_ESP     = 8'd50;
    localparam logic [7:0] NH_AH      = 8'd51;
    localparam logic [7:0] NH_ICMP6   = 8'd58;
    localparam logic [7:0] NH_DSTOPT  = 8'd60;

    // outcome codes
    localparam logic [2:0] OUT_REACHED    = 3'd0;
    localparam logic [2:0] OUT_ICMP_SHORT = 3'd1;
    localparam logic [2:0] OUT_UNKNOWN    = 3'd2;
    localparam logic [2:0] OUT_EXT_OVER   = 3'd3;
    localparam logic [2:0] OUT_ESP        = 3'd4;
    localparam logic [2:0] OUT_TRUNC      = 3'd5;

    // length check codes
    localparam logic [1:0] LEN_EXACT  = 2'd0;
    localparam logic [1:0] LEN_EXCESS = 2'd1;
    localparam logic [1:0] LEN_SHORT  = 2'd2;

    typedef enum logic [2:0] {
        PH_BASE = 3'b001,
        PH_WALK = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } beat_t;

    typedef struct packed {
        logic        version_ok;
        logic [1:0]  length_check;
        logic [15:0] payload_length;
        logic [7:0]  hop_limit;
        logic [7:0]  upper_protocol;
        logic [16:0] upper_offset;
        logic [3:0]  ext_count;
        logic        frag_present;
        logic [15:0] frag_offset;
        logic        more_fragments;
        logic [31:0] frag_ident;
        logic [2:0]  outcome;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/ipv6_extension_header_walker.sv
// ----------------------------------------------------------------------------
// ipv6_extension_header_walker
// Walks the IPv6 base header and extension header chain of a byte stream and
// reports one summary beat per packet.
// ----------------------------------------------------------------------------
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------
//   in      | in_valid / in_stall        | data_byte, last_byte
//   out     | out_valid / out_stall      | version_ok .. outcome (one per pkt)
//
// one byte beat per cycle unless a last byte waits; a beat is held in the input
// register and is folded into the parse state on the edge that takes it
// the result of a packet is loaded into the result register on the edge that
// parses its last byte, so out_valid rises in the cycle after that byte is taken
// reset clears the parse state and both stage valids
// only a last byte waits on a stalled result register, all other bytes flow
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_extension_header_walker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             version_ok,
    output logic [1:0]       length_check,
    output logic [15:0]      payload_length,
    output logic [7:0]       hop_limit,
    output logic [7:0]       upper_protocol,
    output logic [16:0]      upper_offset,
    output logic [3:0]       ext_count,
    output logic             frag_present,
    output logic [15:0]      frag_offset,
    output logic             more_fragments,
    output logic [31:0]      frag_ident,
    output logic [2:0]       outcome
);

    ipv6w_pkg::beat_t   beat;
    ipv6w_pkg::result_t core_result;
    ipv6w_pkg::result_t res;
    logic               out_ready;
    logic               take;

    assign take = beat.valid && (!beat.last || out_ready);

    ipv6w_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .take      (take),
        .beat      (beat)
    );

    ipv6w_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (take),
        .beat   (beat),
        .result (core_result)
    );

    ipv6w_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && beat.last),
        .result_in  (core_result),
        .ready      (out_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (res)
    );

    assign version_ok     = res.version_ok;
    assign length_check   = res.length_check;
    assign payload_length = res.payload_length;
    assign hop_limit      = res.hop_limit;
    assign upper_protocol = res.upper_protocol;
    assign upper_offset   = res.upper_offset;
    assign ext_count      = res.ext_count;
    assign frag_present   = res.frag_present;
    assign frag_offset    = res.frag_offset;
    assign more_fragments = res.more_fragments;
    assign frag_ident     = res.frag_ident;
    assign outcome        = res.outcome;

    // a parsed last byte always leaves a result behind
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        take && beat.last |=> out_valid)
        else $error("last byte parsed without a result");

    // only a held result can back up the input
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> beat.valid && beat.last && out_valid && out_stall)
        else $error("input stalled without a blocked result");

    // bytes other than the last never wait
    a_mid_flows: assert property (@(posedge clk) disable iff (!rst_n)
        beat.valid && !beat.last |-> take)
        else $error("middle byte held back");

endmodule

`default_nettype wire

>>> hw/rtl/ipv6w_in_stage.sv
// ----------------------------------------------------------------------------
// ipv6w_in_stage
// Input register: holds one byte beat until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6w_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    data_byte,
    input  wire logic          last_byte,
    input  wire logic          take,
    output ipv6w_pkg::beat_t   beat
);

    logic       valid_reg;
    logic       last_reg;
    logic [7:0] data_reg;
    logic       load;

    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load || take)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= last_byte;
            data_reg <= data_byte;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.last  = last_reg;
    assign beat.data  = data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ipv6w_core.sv
// ----------------------------------------------------------------------------
// ipv6w_core
// Per-packet parse state: base header capture, length tracking and the
// extension header walk. Builds the packet result on the last beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6w_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  ipv6w_pkg::beat_t       beat,
    output ipv6w_pkg::result_t     result
);

    ipv6w_pkg::phase_t phase_reg, phase_next;
    logic [16:0] byte_index_reg, byte_index_next;
    logic [16:0] eff_end_reg, eff_end_next;
    logic        version_ok_reg, version_ok_next;
    logic [15:0] payload_len_reg, payload_len_next;
    logic [7:0]  hop_limit_reg, hop_limit_next;
    logic [7:0]  cur_next_reg, cur_next_next;
    logic [16:0] hdr_start_reg, hdr_start_next;
    logic [16:0] hdr_end_reg, hdr_end_next;
    logic [7:0]  pend_next_reg, pend_next_next;
    logic [3:0]  ext_cnt_reg, ext_cnt_next;
    logic        frag_present_reg, frag_present_next;
    logic [15:0] frag_off_reg, frag_off_next;
    logic        frag_mf_reg, frag_mf_next;
    logic [31:0] frag_ident_reg, frag_ident_next;
    logic [15:0] cap_off_reg, cap_off_next;
    logic        cap_mf_reg, cap_mf_next;
    logic [31:0] cap_ident_reg, cap_ident_next;
    logic [2:0]  walk_out_reg, walk_out_next;
    logic        excess_reg, excess_next;

    logic [16:0] bidx_inc;
    logic [16:0] rel;
    logic [16:0] hdr_size;
    logic [16:0] icmp_len;
    logic [7:0]  b;

    function automatic ipv6w_pkg::phase_t enter_phase(input logic [7:0] nh);
        ipv6w_pkg::phase_t ph;
        case (nh)
            ipv6w_pkg::NH_HOPOPT,
            ipv6w_pkg::NH_ROUTING,
            ipv6w_pkg::NH_FRAG,
            ipv6w_pkg::NH_AH,
            ipv6w_pkg::NH_DSTOPT: ph = ipv6w_pkg::PH_WALK;
            default:              ph = ipv6w_pkg::PH_DONE;
        endcase
        return ph;
    endfunction

    function automatic logic [2:0] enter_outcome(input logic [7:0] nh);
        logic [2:0] oc;
        case (nh)
            ipv6w_pkg::NH_TCP,
            ipv6w_pkg::NH_UDP,
            ipv6w_pkg::NH_ICMP6: oc = ipv6w_pkg::OUT_REACHED;
            ipv6w_pkg::NH_ESP:   oc = ipv6w_pkg::OUT_ESP;
            default:             oc = ipv6w_pkg::OUT_UNKNOWN;
        endcase
        return oc;
    endfunction

    assign b        = beat.data;
    assign bidx_inc = byte_index_reg + 17'd1;
    assign rel      = byte_index_reg - hdr_start_reg;

    always_comb
    begin
        if (cur_next_reg == ipv6w_pkg::NH_AH)
        begin
            hdr_size = ({9'd0, b} + 17'd2) << 2;
        end
        else if (cur_next_reg == ipv6w_pkg::NH_FRAG)
        begin
            hdr_size = 17'd8;
        end
        else
        begin
            hdr_size = ({9'd0, b} + 17'd1) << 3;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        eff_end_next      = eff_end_reg;
        version_ok_next   = version_ok_reg;
        payload_len_next  = payload_len_reg;
        hop_limit_next    = hop_limit_reg;
        cur_next_next     = cur_next_reg;
        hdr_start_next    = hdr_start_reg;
        hdr_end_next      = hdr_end_reg;
        pend_next_next    = pend_next_reg;
        ext_cnt_next      = ext_cnt_reg;
        frag_present_next = frag_present_reg;
        frag_off_next     = frag_off_reg;
        frag_mf_next      = frag_mf_reg;
        frag_ident_next   = frag_ident_reg;
        cap_off_next      = cap_off_reg;
        cap_mf_next       = cap_mf_reg;
        cap_ident_next    = cap_ident_reg;
        walk_out_next     = walk_out_reg;
        excess_next       = excess_reg;
        icmp_len          = 17'd0;
        result            = '0;

        if (phase_reg == ipv6w_pkg::PH_BASE)
        begin
            case (byte_index_reg)
                17'd0: version_ok_next = (b[7:4] == 4'd6);
                17'd4: payload_len_next = {b, payload_len_reg[7:0]};
                17'd5:
                begin
                    payload_len_next = {payload_len_reg[15:8], b};
                    eff_end_next = {1'b0, payload_len_reg[15:8], b} + ipv6w_pkg::BASE_LEN;
                end
                17'd6: cur_next_next = b;
                17'd7: hop_limit_next = b;
                default: ;
            endcase
            byte_index_next = bidx_inc;
            if (bidx_inc == ipv6w_pkg::BASE_LEN)
            begin
                hdr_start_next = ipv6w_pkg::BASE_LEN;
                phase_next     = enter_phase(cur_next_next);
                walk_out_next  = enter_outcome(cur_next_next);
                hdr_end_next   = 17'd0;
                cap_off_next   = 16'd0;
                cap_mf_next    = 1'b0;
                cap_ident_next = 32'd0;
            end
        end
        else if (byte_index_reg >= eff_end_reg)
        begin
            excess_next = 1'b1;
        end
        else
        begin
            byte_index_next = bidx_inc;
            if (phase_reg == ipv6w_pkg::PH_WALK)
            begin
                if (rel == 17'd0)
                begin
                    pend_next_next = b;
                end
                else if (rel == 17'd1)
                begin
                    hdr_end_next = hdr_start_reg + hdr_size;
                end
                else if (cur_next_reg == ipv6w_pkg::NH_FRAG && rel <= 17'd7)
                begin
                    case (rel[2:0])
                        3'd2: cap_off_next[15:8] = b;
                        3'd3:
                        begin
                            cap_off_next[7:0] = {b[7:3], 3'b000};
                            cap_mf_next       = b[0];
                        end
                        3'd4: cap_ident_next[31:24] = b;
                        3'd5: cap_ident_next[23:16] = b;
                        3'd6: cap_ident_next[15:8]  = b;
                        3'd7: cap_ident_next[7:0]   = b;
                        default: ;
                    endcase
                end

                // header complete on its last byte
                if (rel >= 17'd2 && bidx_inc == hdr_end_reg)
                begin
                    if (ext_cnt_reg < ipv6w_pkg::EXT_COUNT_MAX)
                    begin
                        ext_cnt_next = ext_cnt_reg + 4'd1;
                    end
                    if (cur_next_reg == ipv6w_pkg::NH_FRAG)
                    begin
                        frag_present_next = 1'b1;
                        frag_off_next     = cap_off_next;
                        frag_mf_next      = cap_mf_next;
                        frag_ident_next   = cap_ident_next;
                    end
                    cur_next_next  = pend_next_reg;
                    hdr_start_next = hdr_end_reg;
                    phase_next     = enter_phase(pend_next_reg);
                    walk_out_next  = enter_outcome(pend_next_reg);
                    hdr_end_next   = 17'd0;
                    cap_off_next   = 16'd0;
                    cap_mf_next    = 1'b0;
                    cap_ident_next = 32'd0;
                end
            end
        end

        icmp_len = byte_index_next - hdr_start_next;

        result.version_ok     = version_ok_next;
        result.payload_length = payload_len_next;
        result.hop_limit      = hop_limit_next;
        result.upper_protocol = cur_next_next;
        result.upper_offset   = hdr_start_next;
        result.ext_count      = ext_cnt_next;
        result.frag_present   = frag_present_next;
        result.frag_offset    = frag_off_next;
        result.more_fragments = frag_mf_next;
        result.frag_ident     = frag_ident_next;

        if (phase_next == ipv6w_pkg::PH_BASE)
        begin
            result.outcome      = ipv6w_pkg::OUT_TRUNC;
            result.length_check = ipv6w_pkg::LEN_SHORT;
        end
        else
        begin
            if (phase_next == ipv6w_pkg::PH_WALK)
            begin
                result.outcome = ipv6w_pkg::OUT_EXT_OVER;
            end
            else if (cur_next_next == ipv6w_pkg::NH_ICMP6)
            begin
                result.outcome = (icmp_len >= ipv6w_pkg::ICMP6_MIN) ?
                                 ipv6w_pkg::OUT_REACHED : ipv6w_pkg::OUT_ICMP_SHORT;
            end
            else
            begin
                result.outcome = walk_out_next;
            end

            if (excess_next)
            begin
                result.length_check = ipv6w_pkg::LEN_EXCESS;
            end
            else if (byte_index_next == eff_end_next)
            begin
                result.length_check = ipv6w_pkg::LEN_EXACT;
            end
            else
            begin
                result.length_check = ipv6w_pkg::LEN_SHORT;
            end
        end

        // packet done, back to the start state
        if (beat.last)
        begin
            phase_next        = ipv6w_pkg::PH_BASE;
            byte_index_next   = 17'd0;
            eff_end_next      = 17'd0;
            version_ok_next   = 1'b0;
            payload_len_next  = 16'd0;
            hop_limit_next    = 8'd0;
            cur_next_next     = 8'd0;
            hdr_start_next    = ipv6w_pkg::BASE_LEN;
            hdr_end_next      = 17'd0;
            pend_next_next    = 8'd0;
            ext_cnt_next      = 4'd0;
            frag_present_next = 1'b0;
            frag_off_next     = 16'd0;
            frag_mf_next      = 1'b0;
            frag_ident_next   = 32'd0;
            cap_off_next      = 16'd0;
            cap_mf_next       = 1'b0;
            cap_ident_next    = 32'd0;
            walk_out_next     = 3'd0;
            excess_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ipv6w_pkg::PH_BASE;
            byte_index_reg   <= 17'd0;
            eff_end_reg      <= 17'd0;
            version_ok_reg   <= 1'b0;
            payload_len_reg  <= 16'd0;
            hop_limit_reg    <= 8'd0;
            cur_next_reg     <= 8'd0;
            hdr_start_reg    <= ipv6w_pkg::BASE_LEN;
            hdr_end_reg      <= 17'd0;
            pend_next_reg    <= 8'd0;
            ext_cnt_reg      <= 4'd0;
            frag_present_reg <= 1'b0;
            frag_off_reg     <= 16'd0;
            frag_mf_reg      <= 1'b0;
            frag_ident_reg   <= 32'd0;
            cap_off_reg      <= 16'd0;
            cap_mf_reg       <= 1'b0;
            cap_ident_reg    <= 32'd0;
            walk_out_reg     <= 3'd0;
            excess_reg       <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            eff_end_reg      <= eff_end_next;
            version_ok_reg   <= version_ok_next;
            payload_len_reg  <= payload_len_next;
            hop_limit_reg    <= hop_limit_next;
            cur_next_reg     <= cur_next_next;
            hdr_start_reg    <= hdr_start_next;
            hdr_end_reg      <= hdr_end_next;
            pend_next_reg    <= pend_next_next;
            ext_cnt_reg      <= ext_cnt_next;
            frag_present_reg <= frag_present_next;
            frag_off_reg     <= frag_off_next;
            frag_mf_reg      <= frag_mf_next;
            frag_ident_reg   <= frag_ident_next;
            cap_off_reg      <= cap_off_next;
            cap_mf_reg       <= cap_mf_next;
            cap_ident_reg    <= cap_ident_next;
            walk_out_reg     <= walk_out_next;
            excess_reg       <= excess_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ipv6w_out_stage.sv
// ----------------------------------------------------------------------------
// ipv6w_out_stage
// Result register: holds one packet result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6w_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  ipv6w_pkg::result_t     result_in,
    output logic                   ready,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ipv6w_pkg::result_t     result_out
);

    logic               valid_reg;
    ipv6w_pkg::result_t result_reg;

    // free, or the held result leaves this cycle
    assign ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

`default_nettype wire

>>> bench/tb_ipv6_extension_header_walker.sv
// ----------------------------------------------------------------------------
// tb_ipv6_extension_header_walker
// Self-checking bench for the IPv6 extension header walker. Packets are built
// byte by byte (base header, extension chains, upper payload); some are cut
// short or given a mismatched payload length. Each accepted byte beat drives a
// behavioral walker in the bench, and every summary beat from the block is
// compared field by field against the predicted summary for that packet.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ipv6_extension_header_walker;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] octet_t;

    localparam int unsigned CYCLE_LIMIT = 50000;
    localparam int unsigned DRAIN_CYCLES = 20;
    // least number of bytes sent in each random traffic phase
    localparam int unsigned RANDOM_BYTES = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        version_ok;
    logic [1:0]  length_check;
    logic [15:0] payload_length;
    logic [7:0]  hop_limit;
    logic [7:0]  upper_protocol;
    logic [16:0] upper_offset;
    logic [3:0]  ext_count;
    logic        frag_present;
    logic [15:0] frag_offset;
    logic        more_fragments;
    logic [31:0] frag_ident;
    logic [2:0]  outcome;

    ipv6_extension_header_walker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .version_ok     (version_ok),
        .length_check   (length_check),
        .payload_length (payload_length),
        .hop_limit      (hop_limit),
        .upper_protocol (upper_protocol),
        .upper_offset   (upper_offset),
        .ext_count      (ext_count),
        .frag_present   (frag_present),
        .frag_offset    (frag_offset),
        .more_fragments (more_fragments),
        .frag_ident     (frag_ident),
        .outcome        (outcome)
    );

    always #5 clk = ~clk;

    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned bytes_sent = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    ipv6w_pkg::result_t expected_summaries[$];
    octet_t             pkt_bytes[$];

    // walker state mirrored in the bench
    int unsigned       wk_pos;
    int unsigned       wk_end;
    int unsigned       wk_hstart;
    int unsigned       wk_hend;
    ipv6w_pkg::phase_t wk_phase;
    logic              wk_ver_ok;
    logic [15:0]       wk_plen;
    octet_t            wk_hop;
    octet_t            wk_nh;
    octet_t            wk_pend_nh;
    logic [3:0]        wk_exts;
    logic [2:0]        wk_stop;
    logic              wk_excess;
    logic              wk_frag_seen;
    logic [15:0]       wk_foff;
    logic              wk_more;
    logic [31:0]       wk_ident;
    logic [15:0]       wk_cap_off;
    logic              wk_cap_more;
    logic [31:0]       wk_cap_ident;

    function automatic void walk_clear();
        wk_pos       = 0;
        wk_end       = 0;
        wk_hstart    = 32'(ipv6w_pkg::BASE_LEN);
        wk_hend      = 0;
        wk_phase     = ipv6w_pkg::PH_BASE;
        wk_ver_ok    = 1'b0;
        wk_plen      = '0;
        wk_hop       = '0;
        wk_nh        = '0;
        wk_pend_nh   = '0;
        wk_exts      = '0;
        wk_stop      = ipv6w_pkg::OUT_REACHED;
        wk_excess    = 1'b0;
        wk_frag_seen = 1'b0;
        wk_foff      = '0;
        wk_more      = 1'b0;
        wk_ident     = '0;
        wk_cap_off   = '0;
        wk_cap_more  = 1'b0;
        wk_cap_ident = '0;
    endfunction

    // classify the header that starts at wk_hstart
    function automatic void walk_enter();
        case (wk_nh)
            ipv6w_pkg::NH_TCP, ipv6w_pkg::NH_UDP, ipv6w_pkg::NH_ICMP6:
            begin
                wk_phase = ipv6w_pkg::PH_DONE;
                wk_stop  = ipv6w_pkg::OUT_REACHED;
            end
            ipv6w_pkg::NH_ESP:
            begin
                wk_phase = ipv6w_pkg::PH_DONE;
                wk_stop  = ipv6w_pkg::OUT_ESP;
            end
            ipv6w_pkg::NH_HOPOPT, ipv6w_pkg::NH_ROUTING, ipv6w_pkg::NH_FRAG,
            ipv6w_pkg::NH_AH, ipv6w_pkg::NH_DSTOPT:
            begin
                wk_phase     = ipv6w_pkg::PH_WALK;
                wk_hend      = 0;
                wk_cap_off   = '0;
                wk_cap_more  = 1'b0;
                wk_cap_ident = '0;
            end
            default:
            begin
                wk_phase = ipv6w_pkg::PH_DONE;
                wk_stop  = ipv6w_pkg::OUT_UNKNOWN;
            end
        endcase
    endfunction

    function automatic void walk_ext_byte(octet_t b);
        int unsigned rel;
        rel = wk_pos - wk_hstart;
        if (rel == 0)
        begin
            wk_pend_nh = b;
        end
        else if (rel == 1)
        begin
            if (wk_nh == ipv6w_pkg::NH_AH)
                wk_hend = wk_hstart + (32'(b) + 2) * 4;
            else if (wk_nh == ipv6w_pkg::NH_FRAG)
                wk_hend = wk_hstart + 8;
            else
                wk_hend = wk_hstart + (32'(b) + 1) * 8;
        end
        else if (wk_nh == ipv6w_pkg::NH_FRAG && rel <= 7)
        begin
            if (rel == 2)
                wk_cap_off[15:8] = b;
            else if (rel == 3)
            begin
                wk_cap_off[7:0] = b & 8'hf8;
                wk_cap_more     = b[0];
            end
            else
                wk_cap_ident[8 * (7 - rel) +: 8] = b;
        end
        if (rel >= 2 && wk_pos + 1 == wk_hend)
        begin
            if (wk_exts < ipv6w_pkg::EXT_COUNT_MAX)
                wk_exts++;
            if (wk_nh == ipv6w_pkg::NH_FRAG)
            begin
                wk_frag_seen = 1'b1;
                wk_foff      = wk_cap_off;
                wk_more      = wk_cap_more;
                wk_ident     = wk_cap_ident;
            end
            wk_nh     = wk_pend_nh;
            wk_hstart = wk_hend;
            walk_enter();
        end
    endfunction

    // fold one accepted byte into the walker, queue a summary on the last one
    function automatic void walk_predict(octet_t b, logic is_last);
        ipv6w_pkg::result_t sum;
        if (wk_phase == ipv6w_pkg::PH_BASE)
        begin
            case (wk_pos)
                0: wk_ver_ok = (b[7:4] == 4'd6);
                4: wk_plen[15:8] = b;
                5:
                begin
                    wk_plen[7:0] = b;
                    wk_end       = 32'(wk_plen) + 32'(ipv6w_pkg::BASE_LEN);
                end
                6: wk_nh = b;
                7: wk_hop = b;
                default: ;
            endcase
            wk_pos++;
            if (wk_pos == 32'(ipv6w_pkg::BASE_LEN))
            begin
                wk_hstart = 32'(ipv6w_pkg::BASE_LEN);
                walk_enter();
            end
        end
        else if (wk_pos >= wk_end)
        begin
            wk_excess = 1'b1;
        end
        else
        begin
            if (wk_phase == ipv6w_pkg::PH_WALK)
                walk_ext_byte(b);
            wk_pos++;
        end

        if (!is_last)
            return;

        if (wk_phase == ipv6w_pkg::PH_BASE)
        begin
            sum.outcome      = ipv6w_pkg::OUT_TRUNC;
            sum.length_check = ipv6w_pkg::LEN_SHORT;
        end
        else
        begin
            if (wk_phase == ipv6w_pkg::PH_WALK)
                sum.outcome = ipv6w_pkg::OUT_EXT_OVER;
            else if (wk_nh == ipv6w_pkg::NH_ICMP6)
                sum.outcome = (wk_pos - wk_hstart >= 32'(ipv6w_pkg::ICMP6_MIN)) ?
                              ipv6w_pkg::OUT_REACHED : ipv6w_pkg::OUT_ICMP_SHORT;
            else
                sum.outcome = wk_stop;
            if (wk_excess)
                sum.length_check = ipv6w_pkg::LEN_EXCESS;
            else
                sum.length_check = (wk_pos == wk_end) ?
                                   ipv6w_pkg::LEN_EXACT : ipv6w_pkg::LEN_SHORT;
        end
        sum.version_ok     = wk_ver_ok;
        sum.payload_length = wk_plen;
        sum.hop_limit      = wk_hop;
        sum.upper_protocol = wk_nh;
        sum.upper_offset   = wk_hstart[16:0];
        sum.ext_count      = wk_exts;
        sum.frag_present   = wk_frag_seen;
        sum.frag_offset    = wk_foff;
        sum.more_fragments = wk_more;
        sum.frag_ident     = wk_ident;
        expected_summaries.push_back(sum);
        walk_clear();
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_summary();
        ipv6w_pkg::result_t want;
        if (expected_summaries.size() == 0)
        begin
            $display("%0t: summary beat with no packet pending, expected none, got outcome %0h",
                     $time, outcome);
            errors++;
            return;
        end
        want = expected_summaries.pop_front();
        check_field("version_ok", 32'(want.version_ok), 32'(version_ok));
        check_field("length_check", 32'(want.length_check), 32'(length_check));
        check_field("payload_length", 32'(want.payload_length), 32'(payload_length));
        check_field("hop_limit", 32'(want.hop_limit), 32'(hop_limit));
        check_field("upper_protocol", 32'(want.upper_protocol), 32'(upper_protocol));
        check_field("upper_offset", 32'(want.upper_offset), 32'(upper_offset));
        check_field("ext_count", 32'(want.ext_count), 32'(ext_count));
        check_field("frag_present", 32'(want.frag_present), 32'(frag_present));
        check_field("frag_offset", 32'(want.frag_offset), 32'(frag_offset));
        check_field("more_fragments", 32'(want.more_fragments), 32'(more_fragments));
        check_field("frag_ident", want.frag_ident, frag_ident);
        check_field("outcome", 32'(want.outcome), 32'(outcome));
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            check_summary();
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d summaries outstanding", $time,
                     expected_summaries.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // packet construction
    // ------------------------------------------------------------------------

    function automatic void start_packet(logic [3:0] ver, octet_t nh, octet_t hop);
        int i;
        pkt_bytes.delete();
        pkt_bytes.push_back({ver, 4'($urandom)});
        for (i = 1; i < 40; i++)
            pkt_bytes.push_back(8'($urandom));
        pkt_bytes[6] = nh;
        pkt_bytes[7] = hop;
    endfunction

    function automatic void add_ext(octet_t kind, octet_t nxt, octet_t len);
        int unsigned sz;
        int unsigned i;
        if (kind == ipv6w_pkg::NH_AH)
            sz = (32'(len) + 2) * 4;
        else if (kind == ipv6w_pkg::NH_FRAG)
            sz = 8;
        else
            sz = (32'(len) + 1) * 8;
        pkt_bytes.push_back(nxt);
        pkt_bytes.push_back(len);
        for (i = 2; i < sz; i++)
            pkt_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_frag(octet_t nxt, logic [15:0] off, logic more,
                                     logic [31:0] ident);
        pkt_bytes.push_back(nxt);
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(off[15:8]);
        pkt_bytes.push_back({off[7:3], 2'($urandom), more});
        pkt_bytes.push_back(ident[31:24]);
        pkt_bytes.push_back(ident[23:16]);
        pkt_bytes.push_back(ident[15:8]);
        pkt_bytes.push_back(ident[7:0]);
    endfunction

    function automatic void add_payload(int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            pkt_bytes.push_back(8'($urandom));
    endfunction

    function automatic void set_plen(logic [15:0] plen);
        pkt_bytes[4] = plen[15:8];
        pkt_bytes[5] = plen[7:0];
    endfunction

    function automatic void fix_length();
        set_plen(16'(pkt_bytes.size() - 40));
    endfunction

    function automatic void set_idling(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic send_beat(octet_t b, logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        walk_predict(b, is_last);
        bytes_sent++;
        @(negedge clk);
    endtask

    // send the first n bytes of the packet under construction
    task automatic send_packet(int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            send_beat(pkt_bytes[i], i == n - 1);
    endtask

    task automatic send_whole();
        fix_length();
        send_packet(pkt_bytes.size());
    endtask

    function automatic octet_t pick_ext();
        case ($urandom_range(4))
            0: return ipv6w_pkg::NH_HOPOPT;
            1: return ipv6w_pkg::NH_ROUTING;
            2: return ipv6w_pkg::NH_FRAG;
            3: return ipv6w_pkg::NH_AH;
            default: return ipv6w_pkg::NH_DSTOPT;
        endcase
    endfunction

    function automatic octet_t pick_upper();
        case ($urandom_range(9))
            0, 1: return ipv6w_pkg::NH_TCP;
            2, 3: return ipv6w_pkg::NH_UDP;
            4, 5: return ipv6w_pkg::NH_ICMP6;
            6: return ipv6w_pkg::NH_ESP;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic octet_t pick_len();
        if ($urandom_range(19) == 0)
            return 8'($urandom_range(15));
        return 8'($urandom_range(2));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_upper_protocols();
        start_packet(4'd6, ipv6w_pkg::NH_TCP, 8'd0);
        send_whole();
        start_packet(4'd6, ipv6w_pkg::NH_UDP, 8'd255);
        add_payload(4);
        send_whole();
        // icmpv6 at and just under its minimum size
        start_packet(4'd6, ipv6w_pkg::NH_ICMP6, 8'd64);
        add_payload(8);
        send_whole();
        start_packet(4'd6, ipv6w_pkg::NH_ICMP6, 8'd64);
        add_payload(7);
        send_whole();
        start_packet(4'd6, ipv6w_pkg::NH_ESP, 8'd32);
        send_whole();
        // unknown protocol behind a bad version nibble
        start_packet(4'd0, 8'd59, 8'd32);
        send_whole();
    endtask

    task automatic test_extension_chain();
        int i;
        // every extension kind but the fragment header in one chain
        start_packet(4'd6, ipv6w_pkg::NH_HOPOPT, 8'd17);
        add_ext(ipv6w_pkg::NH_HOPOPT, ipv6w_pkg::NH_ROUTING, 8'd1);
        add_ext(ipv6w_pkg::NH_ROUTING, ipv6w_pkg::NH_DSTOPT, 8'd0);
        add_ext(ipv6w_pkg::NH_DSTOPT, ipv6w_pkg::NH_AH, 8'd2);
        add_ext(ipv6w_pkg::NH_AH, ipv6w_pkg::NH_TCP, 8'd24);
        send_whole();
        // esp stops the walk even after extensions
        start_packet(4'd6, ipv6w_pkg::NH_AH, 8'd9);
        add_ext(ipv6w_pkg::NH_AH, ipv6w_pkg::NH_ESP, 8'd0);
        send_whole();
        // more headers than the counter holds, then a short icmpv6
        start_packet(4'd6, ipv6w_pkg::NH_DSTOPT, 8'd200);
        for (i = 0; i < 16; i++)
            add_ext(ipv6w_pkg::NH_DSTOPT,
                    (i == 15) ? ipv6w_pkg::NH_ICMP6 : ipv6w_pkg::NH_DSTOPT, 8'd0);
        add_payload(3);
        send_whole();
    endtask

    task automatic test_fragment_fields();
        start_packet(4'd6, ipv6w_pkg::NH_FRAG, 8'd64);
        add_frag(ipv6w_pkg::NH_UDP, 16'hffff, 1'b1, 32'hffff_ffff);
        send_whole();
        // the later of two fragment headers is the one reported
        start_packet(4'd6, ipv6w_pkg::NH_FRAG, 8'd64);
        add_frag(ipv6w_pkg::NH_FRAG, 16'h1234, 1'b1, 32'h0bad_cafe);
        add_frag(ipv6w_pkg::NH_TCP, 16'h0008, 1'b0, 32'h1357_9bdf);
        send_whole();
    endtask

    task automatic test_truncation();
        start_packet(4'd6, ipv6w_pkg::NH_TCP, 8'd1);
        set_plen(16'd0);
        send_packet(1);
        send_packet(6);
        send_packet(39);
        // ends at, just past and inside a header far longer than the data
        start_packet(4'd6, ipv6w_pkg::NH_ROUTING, 8'd5);
        add_ext(ipv6w_pkg::NH_ROUTING, ipv6w_pkg::NH_TCP, 8'd255);
        fix_length();
        send_packet(40);
        send_packet(41);
        send_packet(50);
        // half a fragment header is not reported
        start_packet(4'd6, ipv6w_pkg::NH_FRAG, 8'd5);
        add_frag(ipv6w_pkg::NH_UDP, 16'habcd, 1'b1, 32'h89ab_cdef);
        add_payload(8);
        fix_length();
        send_packet(45);
    endtask

    task automatic test_length_check();
        start_packet(4'd6, ipv6w_pkg::NH_TCP, 8'd64);
        add_payload(10);
        set_plen(16'd4);
        send_packet(pkt_bytes.size());
        start_packet(4'd6, ipv6w_pkg::NH_UDP, 8'd64);
        add_payload(4);
        set_plen(16'hffff);
        send_packet(pkt_bytes.size());
        // zero payload length leaves the chain beyond the data
        start_packet(4'd6, ipv6w_pkg::NH_HOPOPT, 8'd64);
        add_ext(ipv6w_pkg::NH_HOPOPT, ipv6w_pkg::NH_TCP, 8'd0);
        set_plen(16'd0);
        send_packet(pkt_bytes.size());
        // icmpv6 cut down by the payload length
        start_packet(4'd6, ipv6w_pkg::NH_ICMP6, 8'd64);
        add_payload(8);
        set_plen(16'd5);
        send_packet(pkt_bytes.size());
    endtask

    task automatic random_packet();
        int unsigned depth;
        int unsigned i;
        int unsigned mode;
        int unsigned cut;
        logic [15:0] plen;
        octet_t kind;
        octet_t nxt;
        octet_t upper;

        upper = pick_upper();
        depth = ($urandom_range(9) == 0) ? $urandom_range(18) : $urandom_range(3);
        kind  = (depth == 0) ? upper : pick_ext();
        start_packet(($urandom_range(99) < 92) ? 4'd6 : 4'($urandom), kind, 8'($urandom));
        for (i = 0; i < depth; i++)
        begin
            nxt = (i == depth - 1) ? upper : pick_ext();
            add_ext(kind, nxt, pick_len());
            kind = nxt;
        end
        add_payload($urandom_range(12));
        fix_length();
        plen = 16'(pkt_bytes.size() - 40);
        cut  = pkt_bytes.size();
        mode = $urandom_range(99);
        if (mode < 10)
            cut = $urandom_range(39, 1);
        else if (mode < 22)
            cut = 40 + $urandom_range(pkt_bytes.size() - 40);
        else if (mode < 32)
            set_plen(plen - 16'($urandom_range(plen)));
        else if (mode < 36)
            set_plen(16'($urandom));
        send_packet(cut);
    endtask

    task automatic test_random_traffic();
        int ph;
        int unsigned start_bytes;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_idling(0, 0);
                1: set_idling(76, 0);
                2: set_idling(0, 76);
                default: set_idling(36, 36);
            endcase
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < RANDOM_BYTES)
                random_packet();
        end
    endtask

    initial
    begin
        walk_clear();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(0, 0);
        test_upper_protocols();
        set_idling(76, 0);
        test_extension_chain();
        set_idling(0, 76);
        test_fragment_fields();
        set_idling(36, 36);
        test_truncation();
        test_length_check();
        test_random_traffic();

        in_valid <= 1'b0;
        set_idling(0, 0);
        while (expected_summaries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
